### hw/rtl/positional_array_list_defines.svh
// assertion macros used by the positional array list rtl
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pal_pkg.sv
// shared types and codes of the positional array list
package pal_pkg;

  // request codes
  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_POS   = 3'd1;
  localparam logic [2:0] REQ_INS_END   = 3'd2;
  localparam logic [2:0] REQ_RM_FRONT  = 3'd3;
  localparam logic [2:0] REQ_RM_POS    = 3'd4;
  localparam logic [2:0] REQ_RM_END    = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // field widths of the transaction payloads
  localparam int unsigned PosW  = 7;
  localparam int unsigned WordW = 32;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [PosW-1:0]  position;
    logic [WordW-1:0] entry_data;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] removed_data;
    logic             removed_valid;
    logic [1:0]       status;
    logic [PosW-1:0]  entry_count;
  } rsp_t;

endpackage

### hw/rtl/pal_mem.sv
// single-port-write, registered-read entry memory
module pal_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pal_seq.sv
// sequencer that shifts list entries one at a time through the memory port
`include "positional_array_list_defines.svh"

module pal_seq #(
  parameter int unsigned Capacity  = 64,
  parameter int unsigned DataWidth = 32,
  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CntW  = $clog2(Capacity + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  pal_pkg::req_t        req_i,
  output logic                 done_o,
  output pal_pkg::rsp_t        rsp_o,
  // memory port
  output logic                 mem_we_o,
  output logic [AddrW-1:0]     mem_waddr_o,
  output logic [DataWidth-1:0] mem_wdata_o,
  output logic [AddrW-1:0]     mem_raddr_o,
  input  logic [DataWidth-1:0] mem_rdata_i
);

  localparam int unsigned CmpW = (CntW > pal_pkg::PosW) ? CntW : pal_pkg::PosW;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_WR, S_PLACE, S_TAKE, S_CAP, S_DN_RD, S_DN_WR, S_FINISH
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      count_q;
  logic [CntW-1:0]      idx_q;
  logic [CntW-1:0]      tgt_q;
  logic [DataWidth-1:0] word_q;
  logic [DataWidth-1:0] removed_q;
  logic                 done_q;
  pal_pkg::rsp_t        rsp_q;

  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic            is_full, is_empty, ins_bad, rm_bad;
  logic [CntW-1:0] idx_dec, idx_inc, cnt_dec, pos_cnt;
  logic [CntW:0]   idx_inc2;

  // request checks and index arithmetic
  always_comb begin
    pos_ext  = CmpW'(req_i.position);
    cnt_ext  = CmpW'(count_q);
    is_full  = count_q >= CntW'(Capacity);
    is_empty = count_q == '0;
    ins_bad  = pos_ext > cnt_ext;
    rm_bad   = pos_ext >= cnt_ext;
    pos_cnt  = CntW'(req_i.position);
    idx_dec  = idx_q - 1'b1;
    idx_inc  = idx_q + 1'b1;
    idx_inc2 = {1'b0, idx_q} + (CntW+1)'(2);
    cnt_dec  = count_q - 1'b1;
  end

  // memory port control
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AddrW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = tgt_q[AddrW-1:0];
    unique case (state_q)
      S_UP_RD: mem_raddr_o = idx_dec[AddrW-1:0];
      S_UP_WR: mem_we_o    = 1'b1;
      S_PLACE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q[AddrW-1:0];
        mem_wdata_o = word_q;
      end
      S_DN_RD: mem_raddr_o = idx_inc[AddrW-1:0];
      S_DN_WR: mem_we_o    = 1'b1;
      default: ;
    endcase
  end

  // state, list length and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            word_q                    <= DataWidth'(req_i.entry_data);
            rsp_q.removed_data        <= '0;
            rsp_q.removed_valid       <= 1'b0;
            rsp_q.entry_count         <= pal_pkg::PosW'(count_q);
            rsp_q.status              <= pal_pkg::ST_OK;
            unique case (req_i.req_type)
              pal_pkg::REQ_INS_FRONT, pal_pkg::REQ_INS_POS, pal_pkg::REQ_INS_END: begin
                if (is_full) begin
                  rsp_q.status <= pal_pkg::ST_FULL;
                  done_q       <= 1'b1;
                end else if (req_i.req_type == pal_pkg::REQ_INS_POS && ins_bad) begin
                  rsp_q.status <= pal_pkg::ST_RANGE;
                  done_q       <= 1'b1;
                end else begin
                  idx_q <= count_q;
                  if (req_i.req_type == pal_pkg::REQ_INS_FRONT) begin
                    tgt_q   <= '0;
                    state_q <= is_empty ? S_PLACE : S_UP_RD;
                  end else if (req_i.req_type == pal_pkg::REQ_INS_END) begin
                    tgt_q   <= count_q;
                    state_q <= S_PLACE;
                  end else begin
                    tgt_q   <= pos_cnt;
                    state_q <= (pos_cnt == count_q) ? S_PLACE : S_UP_RD;
                  end
                end
              end
              pal_pkg::REQ_RM_FRONT, pal_pkg::REQ_RM_POS, pal_pkg::REQ_RM_END: begin
                if (is_empty) begin
                  rsp_q.status <= pal_pkg::ST_EMPTY;
                  done_q       <= 1'b1;
                end else if (req_i.req_type == pal_pkg::REQ_RM_POS && rm_bad) begin
                  rsp_q.status <= pal_pkg::ST_RANGE;
                  done_q       <= 1'b1;
                end else begin
                  state_q <= S_TAKE;
                  if (req_i.req_type == pal_pkg::REQ_RM_FRONT) begin
                    tgt_q <= '0;
                    idx_q <= '0;
                  end else if (req_i.req_type == pal_pkg::REQ_RM_END) begin
                    tgt_q <= cnt_dec;
                    idx_q <= cnt_dec;
                  end else begin
                    tgt_q <= pos_cnt;
                    idx_q <= pos_cnt;
                  end
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        // move entry idx-1 up to idx
        S_UP_RD: state_q <= S_UP_WR;
        S_UP_WR: begin
          idx_q   <= idx_dec;
          state_q <= (idx_dec == tgt_q) ? S_PLACE : S_UP_RD;
        end
        S_PLACE: begin
          count_q           <= count_q + 1'b1;
          rsp_q.entry_count <= pal_pkg::PosW'(count_q + 1'b1);
          done_q            <= 1'b1;
          state_q           <= S_IDLE;
        end
        // read of the removed word in flight
        S_TAKE: state_q <= S_CAP;
        S_CAP: begin
          removed_q <= mem_rdata_i;
          state_q   <= (idx_inc < count_q) ? S_DN_RD : S_FINISH;
        end
        // move entry idx+1 down to idx
        S_DN_RD: state_q <= S_DN_WR;
        S_DN_WR: begin
          idx_q   <= idx_inc;
          state_q <= (idx_inc2 < {1'b0, count_q}) ? S_DN_RD : S_FINISH;
        end
        S_FINISH: begin
          count_q             <= cnt_dec;
          rsp_q.entry_count   <= pal_pkg::PosW'(cnt_dec);
          rsp_q.removed_data  <= pal_pkg::WordW'(removed_q);
          rsp_q.removed_valid <= 1'b1;
          done_q              <= 1'b1;
          state_q             <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // checks
  `PAL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(Capacity),
    "list length beyond capacity")
  `PAL_ASSERT_NEXT(a_accept_progress, start_i && !busy_o, done_o || busy_o,
    "accepted transaction neither reported nor in progress")
  `PAL_ASSERT_NOW(a_removed_ok, done_o && rsp_o.removed_valid,
    rsp_o.status == pal_pkg::ST_OK, "removed word reported with error status")
  `PAL_ASSERT_NOW(a_error_keeps_list, done_o && rsp_o.status != pal_pkg::ST_OK,
    count_q == $past(count_q), "failed request changed the list length")

endmodule

### hw/rtl/positional_array_list.sv
// top level of the positional array list
//
//  channel   signals                    transfer
//  request   start, busy, req_i         taken at a rising edge with start high, busy low
//  result    done_o, rsp_o              one cycle wide strobe, always taken
//
// an error or unused request code reports in the cycle after acceptance
// insert at index p moves the entries from p on up by one, remove at index p moves those after p down by one
// each entry moved costs one read and one write on the memory port
// reset clears the list length, state and result strobe; entry contents are never cleared
// the result side has no stall, busy is high until the result strobe
module positional_array_list #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pal_pkg::req_t req_i,
  output logic          done_o,
  output pal_pkg::rsp_t rsp_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [AddrW-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // request sequencer
  pal_seq #(
    .Capacity (CAPACITY),
    .DataWidth(DATA_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // entry storage
  pal_mem #(
    .Depth(CAPACITY),
    .Width(DATA_WIDTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
